[hdl/pip_pkg.sv]
package pip_pkg;

	localparam int MAX_OFFSETS   = 14;
	localparam int IDX_W         = 4;
	localparam int OFF_W         = 6;
	localparam int CAP_W         = 7;
	localparam int PAT_W         = 3;
	localparam int CAP_BACK_BASE = 2;

	localparam logic [PAT_W-1:0] PAT_NORMAL      = 3'd0;
	localparam logic [PAT_W-1:0] PAT_NORMAL_FWD  = 3'd1;
	localparam logic [PAT_W-1:0] PAT_NORMAL_BACK = 3'd2;
	localparam logic [PAT_W-1:0] PAT_FAST_FWD    = 3'd3;
	localparam logic [PAT_W-1:0] PAT_FAST_BACK   = 3'd4;

	localparam logic [0:0] REG_CACHE_CAPACITY = 1'd0;
	localparam logic [0:0] REG_PAGE_COUNT     = 1'd1;

	typedef logic signed [OFF_W-1:0] offset_t;

	// pattern plus the entries that survive the capacity cut
	typedef struct packed {
		logic [PAT_W-1:0]       pattern;
		logic [MAX_OFFSETS-1:0] keep;
	} plan_t;

	// tables padded to sixteen entries, padding lies beyond each table length
	localparam offset_t TAB_NORMAL [16] = '{
		6'sd0, 6'sd1, 6'sd2, 6'sd3, -6'sd1, -6'sd2, 6'sd4, 6'sd5,
		-6'sd3, -6'sd4, 6'sd6, 6'sd7, -6'sd5, -6'sd6, 6'sd0, 6'sd0};
	localparam offset_t TAB_FWD [16] = '{
		6'sd10, 6'sd11, 6'sd8, 6'sd9, 6'sd0, 6'sd1, 6'sd2, 6'sd3,
		6'sd4, 6'sd5, 6'sd6, 6'sd7, 6'sd0, 6'sd0, 6'sd0, 6'sd0};
	localparam offset_t TAB_BACK [16] = '{
		-6'sd9, -6'sd10, -6'sd7, -6'sd8, 6'sd0, 6'sd1, -6'sd1, -6'sd2,
		-6'sd3, -6'sd4, -6'sd5, -6'sd6, 6'sd0, 6'sd0, 6'sd0, 6'sd0};
	localparam offset_t TAB_FFWD [16] = '{
		6'sd0, 6'sd1, 6'sd10, 6'sd11, -6'sd10, -6'sd9, 6'sd20, 6'sd21,
		-6'sd20, -6'sd19, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0};
	localparam offset_t TAB_FBACK [16] = '{
		6'sd0, 6'sd1, -6'sd10, -6'sd9, 6'sd10, 6'sd11, -6'sd20, -6'sd19,
		6'sd20, 6'sd21, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0};

	function automatic offset_t table_offset(input logic [PAT_W-1:0] pat,
	                                         input logic [IDX_W-1:0] idx);
		offset_t off;
		unique case (pat)
			PAT_NORMAL:      off = TAB_NORMAL[idx];
			PAT_NORMAL_FWD:  off = TAB_FWD[idx];
			PAT_NORMAL_BACK: off = TAB_BACK[idx];
			PAT_FAST_FWD:    off = TAB_FFWD[idx];
			PAT_FAST_BACK:   off = TAB_FBACK[idx];
			default:         off = '0;
		endcase
		return off;
	endfunction

	function automatic logic [IDX_W-1:0] table_len(input logic [PAT_W-1:0] pat);
		logic [IDX_W-1:0] len;
		unique case (pat) inside
			PAT_NORMAL:                      len = 4'd14;
			PAT_NORMAL_FWD, PAT_NORMAL_BACK: len = 4'd12;
			PAT_FAST_FWD, PAT_FAST_BACK:     len = 4'd10;
			default:                         len = 4'd0;
		endcase
		return len;
	endfunction

endpackage

[hdl/pip_front.sv]
module pip_front #(
	parameter int PAGE_BITS = 16
) (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [PAGE_BITS-1:0]        current_page,
	input  logic [pip_pkg::PAT_W-1:0]   pattern,
	input  logic [pip_pkg::CAP_W-1:0]   cache_capacity,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [PAGE_BITS-1:0]        q_page,
	output pip_pkg::plan_t              q_plan
);

	// capacity cut for one table entry
	function automatic logic keep_bit(input logic [pip_pkg::PAT_W-1:0] pat,
	                                  input logic [pip_pkg::IDX_W-1:0] idx,
	                                  input logic [pip_pkg::CAP_W-1:0] cap);
		pip_pkg::offset_t        off;
		logic [pip_pkg::IDX_W-1:0] len;
		logic signed [7:0]       off8;
		logic signed [7:0]       cap8;
		logic signed [7:0]       back_lim;
		logic                    in_tab;
		logic                    longer;
		logic                    k;
		off      = pip_pkg::table_offset(pat, idx);
		len      = pip_pkg::table_len(pat);
		off8     = 8'(off);
		cap8     = $signed({1'b0, cap});
		back_lim = 8'(pip_pkg::CAP_BACK_BASE) - cap8;
		in_tab   = idx < len;
		longer   = {3'b000, len} > cap;
		case (pat)
			pip_pkg::PAT_NORMAL_FWD:  k = in_tab && !(longer && (off8 >= cap8));
			pip_pkg::PAT_NORMAL_BACK: k = in_tab && !(longer && (off8 < back_lim));
			default:                  k = in_tab && ({3'b000, idx} < cap);
		endcase
		return k;
	endfunction

	always_comb begin
		q_plan.pattern = pattern;
		for (int i = 0; i < pip_pkg::MAX_OFFSETS; i++) begin
			q_plan.keep[i] = keep_bit(pattern, pip_pkg::IDX_W'(i), cache_capacity);
		end
	end

	assign q_page   = current_page;
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

[hdl/pip_queue.sv]
module pip_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head_data,
	output logic              not_empty,
	output logic              full
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign head_data = mem_q[rd_ptr_q];
	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'd2;

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");
`endif

endmodule

[hdl/pip_back.sv]
module pip_back #(
	parameter int PAGE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  logic [PAGE_BITS-1:0]  q_page,
	input  pip_pkg::plan_t        q_plan,
	output logic                  q_pop,
	input  logic [PAGE_BITS-1:0]  page_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PAGE_BITS-1:0]  page_index,
	output logic                  valid_res,
	output logic                  last
);

	localparam int N = pip_pkg::MAX_OFFSETS;
	localparam int SUM_W = PAGE_BITS + 2;

	logic                       busy_q;
	logic [PAGE_BITS-1:0]       cur_q;
	logic [pip_pkg::PAT_W-1:0]  pat_q;
	logic [N-1:0]               mask_q;

	logic                       out_valid_q;
	logic [PAGE_BITS-1:0]       page_q;
	logic                       vres_q;
	logic                       last_q;

	logic [N-1:0]               mask_in;
	logic [N-1:0]               low_bit;
	logic [N-1:0]               mask_rest;
	logic [pip_pkg::IDX_W-1:0]  low_idx;
	pip_pkg::offset_t           sel_off;
	logic [PAGE_BITS-1:0]       sel_page;
	logic                       load;
	logic                       finishing;

	// range check of every kept entry as the item leaves the queue
	always_comb begin
		pip_pkg::offset_t  off;
		logic [SUM_W-1:0]  sum;
		for (int i = 0; i < N; i++) begin
			off = pip_pkg::table_offset(q_plan.pattern, pip_pkg::IDX_W'(i));
			sum = {2'b00, q_page} + {{(SUM_W-pip_pkg::OFF_W){off[pip_pkg::OFF_W-1]}}, off};
			mask_in[i] = q_plan.keep[i] && !sum[SUM_W-1]
			             && (sum[PAGE_BITS:0] < {1'b0, page_count});
		end
	end

	// walk the survivor mask lowest entry first
	always_comb begin
		low_bit   = mask_q & (~mask_q + N'(1));
		mask_rest = mask_q & ~low_bit;
		low_idx   = '0;
		for (int i = 0; i < N; i++) begin
			if (low_bit[i]) begin
				low_idx = pip_pkg::IDX_W'(i);
			end
		end
		sel_off  = pip_pkg::table_offset(pat_q, low_idx);
		sel_page = cur_q + {{(PAGE_BITS-pip_pkg::OFF_W){sel_off[pip_pkg::OFF_W-1]}}, sel_off};
	end

	assign load      = !out_valid_q || !out_stall;
	assign finishing = busy_q && load && (mask_rest == '0);
	assign q_pop     = q_not_empty && (!busy_q || finishing);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				mask_q <= mask_in;
			end else if (finishing) begin
				busy_q <= 1'b0;
				mask_q <= '0;
			end else if (busy_q && load) begin
				mask_q <= mask_rest;
			end
			if (load) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_page;
			pat_q <= q_plan.pattern;
		end
		if (busy_q && load) begin
			page_q <= (mask_q == '0) ? '0 : sel_page;
			vres_q <= mask_q != '0;
			last_q <= mask_rest == '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign page_index = page_q;
	assign valid_res  = vres_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !vres_q) |-> last_q)
		else $error("empty plan result without last");
	a_idle_mask_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (mask_q == '0))
		else $error("survivor mask left over while idle");
	a_pop_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && busy_q) |-> (load && (mask_rest == '0)))
		else $error("new item taken before the walk ended");
`endif

endmodule

[hdl/prefetch_index_planner_core.sv]
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     current_page, pattern
// out       output     out_valid / out_stall   page_index, valid_res, last
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// a request gives max(1, surviving entries) results, up to 14, one per cycle while out_stall is low,
// set by the back walk over the survivor mask, one table entry per output transfer
// a two-entry queue between classifier and walker takes new requests during a walk
// the range check against page_count is done as the request leaves the queue
// reset sets cache_capacity to 14 and page_count to 0 and empties the queue
// out_stall holds the output register and the walk, in_stall rises when the queue is full
module prefetch_index_planner_core #(
	parameter int PAGE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [PAGE_BITS-1:0]       cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [PAGE_BITS-1:0]       current_page,
	input  logic [pip_pkg::PAT_W-1:0]  pattern,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [PAGE_BITS-1:0]       page_index,
	output logic                       valid_res,
	output logic                       last
);

	localparam int PLAN_W = $bits(pip_pkg::plan_t);
	localparam int Q_W    = PAGE_BITS + PLAN_W;

	// configuration registers
	logic [pip_pkg::CAP_W-1:0] cache_capacity_q;
	logic [PAGE_BITS-1:0]      page_count_q;

	// front to queue
	logic                      q_push;
	logic [PAGE_BITS-1:0]      front_page;
	pip_pkg::plan_t            front_plan;

	// queue to back
	logic                      q_pop;
	logic                      q_not_empty;
	logic                      q_full;
	logic [Q_W-1:0]            q_head;
	logic [PAGE_BITS-1:0]      head_page;
	pip_pkg::plan_t            head_plan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_capacity_q <= pip_pkg::CAP_W'(14);
			page_count_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pip_pkg::REG_CACHE_CAPACITY: cache_capacity_q <= cfg_data[pip_pkg::CAP_W-1:0];
				pip_pkg::REG_PAGE_COUNT:     page_count_q     <= cfg_data;
				default:                     ;
			endcase
		end
	end

	// classify and cut the table by capacity
	pip_front #(
		.PAGE_BITS(PAGE_BITS)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.current_page  (current_page),
		.pattern       (pattern),
		.cache_capacity(cache_capacity_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_page        (front_page),
		.q_plan        (front_plan)
	);

	// decouples request intake from result delivery
	pip_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({front_page, front_plan}),
		.pop      (q_pop),
		.head_data(q_head),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	assign head_page = q_head[Q_W-1:PLAN_W];
	assign head_plan = q_head[PLAN_W-1:0];

	// range check and one result per transfer
	pip_back #(
		.PAGE_BITS(PAGE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_page     (head_page),
		.q_plan     (head_plan),
		.q_pop      (q_pop),
		.page_count (page_count_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.page_index (page_index),
		.valid_res  (valid_res),
		.last       (last)
	);

endmodule
